// ----- hw/rtl/efc_pkg.sv -----
// Shared types, constants and lookup functions for the fly camera update block.
`timescale 1ns / 1ps
`default_nettype none
package efc_pkg;

  localparam int VEC_BITS = 16;
  localparam int POS_BITS = 32;
  localparam int MUL_BITS = 32;

  localparam logic [16:0] FULL_TURN    = 17'd92160;
  localparam logic [16:0] QUARTER_TURN = 17'd23040;
  localparam logic [16:0] EIGHTH_TURN  = 17'd11520;
  localparam logic signed [20:0] PITCH_LIM = 21'sd22784;
  localparam logic [31:0] RAD_Q30 = 32'd18740330;
  localparam logic [30:0] TRIG_ONE = 31'h4000_0000;
  localparam logic signed [VEC_BITS-1:0] VEC_MAX = 16'sd32767;

  // Register indexes
  localparam logic [2:0] REG_MANUAL = 3'd0;
  localparam logic [2:0] REG_SPEED  = 3'd1;
  localparam logic [2:0] REG_GAIN   = 3'd2;
  localparam logic [2:0] REG_SYAW   = 3'd3;
  localparam logic [2:0] REG_SPITCH = 3'd4;
  localparam logic [2:0] REG_SX     = 3'd5;
  localparam logic [2:0] REG_SY     = 3'd6;
  localparam logic [2:0] REG_SZ     = 3'd7;

  // Last series term index of the sine and cosine evaluations
  localparam logic [3:0] SIN_LAST = 4'd4;
  localparam logic [3:0] COS_LAST = 4'd10;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_DX_ISS, S_DX_USE, S_DY_USE, S_VEL_USE, S_WRAP,
    S_FS_ISS, S_FS_USE, S_RS_ISS, S_RS_USE, S_APPLY,
    S_FOLD, S_X_USE, S_X2_ISS, S_X2_USE, S_PM_ISS, S_PM_USE, S_RC_USE, S_QD_USE,
    S_SIN_ISS, S_SIN_USE, S_QUAD, S_PR_ISS, S_PR_USE, S_DONE
  } state_t;

  // Series divisors: sine terms first, then cosine terms
  function automatic logic [7:0] poly_div(input logic [3:0] j);
    logic [7:0] d;
    case (j)
      4'd0:    d = 8'd110;
      4'd1:    d = 8'd72;
      4'd2:    d = 8'd42;
      4'd3:    d = 8'd20;
      4'd4:    d = 8'd6;
      4'd5:    d = 8'd132;
      4'd6:    d = 8'd90;
      4'd7:    d = 8'd56;
      4'd8:    d = 8'd30;
      4'd9:    d = 8'd12;
      default: d = 8'd2;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor)
  function automatic logic [31:0] poly_recip(input logic [3:0] j);
    logic [31:0] r;
    case (j)
      4'd0:    r = 32'd39045157;
      4'd1:    r = 32'd59652323;
      4'd2:    r = 32'd102261126;
      4'd3:    r = 32'd214748364;
      4'd4:    r = 32'd715827882;
      4'd5:    r = 32'd32537631;
      4'd6:    r = 32'd47721858;
      4'd7:    r = 32'd76695844;
      4'd8:    r = 32'd143165576;
      4'd9:    r = 32'd357913941;
      default: r = 32'd2147483648;
    endcase
    return r;
  endfunction

  // Q30 to Q1.15: round magnitude half away from zero, saturate
  function automatic logic signed [VEC_BITS-1:0] quant(input logic signed [31:0] v);
    logic [31:0] m;
    logic [31:0] r;
    logic [15:0] q;
    m = v[31] ? (32'd0 - v) : v;
    r = (m + 32'h4000) >> 15;
    q = (r > 32'd32767) ? 16'd32767 : r[15:0];
    return v[31] ? $signed(16'd0 - q) : $signed(q);
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/efc_mul.sv -----
// Shared unsigned multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module efc_mul (
  input  wire logic                                clk,
  input  wire logic [efc_pkg::MUL_BITS-1:0]        a,
  input  wire logic [efc_pkg::MUL_BITS-1:0]        b,
  output logic      [2*efc_pkg::MUL_BITS-1:0]      p
);

  // Register the product for the next sequencer step
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/euler_fly_camera_update.sv -----
// Top level of the fly camera update block: registers, sequencer and datapath.
`timescale 1ns / 1ps
`default_nettype none
// One frame tick per item. A small sequencer runs every multiply of the tick
// through one shared 32x32 multiplier and takes no new item until the last one
// is done: the look update, the yaw wrap and the key moves (these only with
// manual control on), a sine/cosine evaluation of yaw, then of pitch (each a
// folded octant series with reciprocal divides), the basis products and the
// load of the output register.
// Input stall is high from acceptance until the result is loaded into the output
// register; the next item can be taken while that result waits.
module euler_fly_camera_update (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        restart,
  input  wire logic signed [11:0] mouse_dx,
  input  wire logic signed [11:0] mouse_dy,
  input  wire logic        key_forward,
  input  wire logic        key_back,
  input  wire logic        key_left,
  input  wire logic        key_right,
  input  wire logic [15:0] dt,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [15:0] front_x,
  output logic signed [15:0] front_y,
  output logic signed [15:0] front_z,
  output logic signed [15:0] right_x,
  output logic signed [15:0] right_y,
  output logic signed [15:0] right_z,
  output logic signed [15:0] up_x,
  output logic signed [15:0] up_y,
  output logic signed [15:0] up_z
);

  // Configuration registers
  logic        manual_enable;
  logic [15:0] move_speed, look_gain;
  logic [16:0] start_yaw;
  logic [15:0] start_pitch;
  logic [31:0] start_x, start_y, start_z;

  assign pready = 1'b1;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      manual_enable <= 1'b0;
      move_speed    <= 16'd640;
      look_gain     <= 16'd6554;
      start_yaw     <= 17'd69120;
      start_pitch   <= 16'd0;
      start_x       <= 32'd0;
      start_y       <= 32'd0;
      start_z       <= 32'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        efc_pkg::REG_MANUAL: manual_enable <= pwdata[0];
        efc_pkg::REG_SPEED:  move_speed    <= pwdata[15:0];
        efc_pkg::REG_GAIN:   look_gain     <= pwdata[15:0];
        efc_pkg::REG_SYAW:   start_yaw     <= pwdata[16:0];
        efc_pkg::REG_SPITCH: start_pitch   <= pwdata[15:0];
        efc_pkg::REG_SX:     start_x       <= pwdata;
        efc_pkg::REG_SY:     start_y       <= pwdata;
        efc_pkg::REG_SZ:     start_z       <= pwdata;
        default: ;
      endcase
    end
  end

  // Read configuration
  always_comb begin
    case (paddr[4:2])
      efc_pkg::REG_MANUAL: prdata = {31'd0, manual_enable};
      efc_pkg::REG_SPEED:  prdata = {16'd0, move_speed};
      efc_pkg::REG_GAIN:   prdata = {16'd0, look_gain};
      efc_pkg::REG_SYAW:   prdata = {15'd0, start_yaw};
      efc_pkg::REG_SPITCH: prdata = {{16{start_pitch[15]}}, start_pitch};
      efc_pkg::REG_SX:     prdata = start_x;
      efc_pkg::REG_SY:     prdata = start_y;
      default:             prdata = start_z;
    endcase
  end

  // Sequencer and datapath state
  efc_pkg::state_t state, state_next;
  logic             out_free;

  logic signed [11:0] l_dx, l_dy;
  logic [3:0]       l_keys;
  logic [15:0]      l_dt;

  logic [16:0]        yaw;
  logic signed [15:0] pitch;
  logic signed [31:0] pos [3];
  logic signed [15:0] front [3];
  logic signed [15:0] right [3];

  logic signed [20:0] ysum;
  logic [31:0]        vel;
  logic signed [25:0] fs, rs;
  logic [1:0]         idx, kcnt, pk;
  logic               sel;
  logic [3:0]         j;
  logic [1:0]         quad;
  logic               swap;
  logic [29:0]        x;
  logic [30:0]        x2, t, pm, s0, c0;
  logic [29:0]        q0;
  logic signed [31:0] sy, cy, sp, cp;
  logic signed [15:0] upx, upz;

  logic [31:0] ma, mb;
  logic [63:0] mp;

  efc_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  assign in_stall = (state != efc_pkg::S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Combinational helpers
  logic [11:0]        dx_mag, dy_mag;
  logic [19:0]        d_mag;
  logic signed [20:0] d_sig, psum;
  logic [16:0]        ang_u, r_u, rr;
  logic [1:0]         q_u;
  logic [15:0]        fv_mag, rv_mag;
  logic [24:0]        step_mag;
  logic [30:0]        rnd30;
  logic [30:0]        rem;
  logic [29:0]        qfix;
  logic [30:0]        t_new;
  logic [30:0]        s_oct, c_oct;
  logic signed [31:0] s_q, c_q;
  logic signed [31:0] prod_s;
  logic signed [25:0] delta;
  logic               key_on;
  logic signed [32:0] pos_sum;
  logic signed [31:0] pos_sat;
  logic signed [31:0] pa, pb;

  always_comb begin
    dx_mag   = l_dx[11] ? (12'd0 - l_dx) : l_dx;
    dy_mag   = l_dy[11] ? (12'd0 - l_dy) : l_dy;
    d_mag    = 20'((mp[27:0] + 28'd128) >> 8);
    rnd30    = 31'((mp[61:0] + 62'h2000_0000) >> 30);
    step_mag = 25'((mp[47:0] + 48'h40_0000) >> 23);
    fv_mag   = front[idx][15] ? (16'd0 - front[idx]) : front[idx];
    rv_mag   = right[idx][15] ? (16'd0 - right[idx]) : right[idx];
    // Fold the angle to one octant
    ang_u = sel ? ((pitch < 0) ? 17'(efc_pkg::FULL_TURN + 17'(pitch)) : 17'(pitch)) : yaw;
    if (ang_u >= 17'd69120)      q_u = 2'd3;
    else if (ang_u >= 17'd46080) q_u = 2'd2;
    else if (ang_u >= 17'd23040) q_u = 2'd1;
    else                         q_u = 2'd0;
    r_u = ang_u - 17'(q_u * efc_pkg::QUARTER_TURN);
    rr  = (r_u > efc_pkg::EIGHTH_TURN) ? (efc_pkg::QUARTER_TURN - r_u) : r_u;
    // Reciprocal quotient correction
    rem   = pm - mp[30:0];
    qfix  = (rem >= {23'd0, efc_pkg::poly_div(j)}) ? (q0 + 30'd1) : q0;
    t_new = efc_pkg::TRIG_ONE - {1'b0, qfix};
    // Undo the octant fold, then map the quadrant
    s_oct = swap ? c0 : s0;
    c_oct = swap ? s0 : c0;
    case (quad)
      2'd0:    begin s_q = $signed({1'b0, s_oct});  c_q = $signed({1'b0, c_oct}); end
      2'd1:    begin s_q = $signed({1'b0, c_oct});  c_q = -$signed({1'b0, s_oct}); end
      2'd2:    begin s_q = -$signed({1'b0, s_oct}); c_q = -$signed({1'b0, c_oct}); end
      default: begin s_q = -$signed({1'b0, c_oct}); c_q = $signed({1'b0, s_oct}); end
    endcase
    // Basis product operands
    case (pk)
      2'd0:    begin pa = cy; pb = cp; end
      2'd1:    begin pa = sy; pb = cp; end
      2'd2:    begin pa = cy; pb = sp; end
      default: begin pa = sy; pb = sp; end
    endcase
    prod_s = ((pa < 0) != (pb < 0)) ? -$signed({1'b0, rnd30}) : $signed({1'b0, rnd30});
    // One key move per cycle
    case (kcnt)
      2'd0:    begin key_on = l_keys[0]; delta = fs;  end
      2'd1:    begin key_on = l_keys[1]; delta = -fs; end
      2'd2:    begin key_on = l_keys[2]; delta = -rs; end
      default: begin key_on = l_keys[3]; delta = rs;  end
    endcase
    pos_sum = 33'(pos[idx]) + 33'(delta);
    if (pos_sum > 33'sd2147483647)       pos_sat = 32'sh7FFF_FFFF;
    else if (pos_sum < -33'sd2147483648) pos_sat = 32'sh8000_0000;
    else                                 pos_sat = pos_sum[31:0];
    d_sig = 21'sd0;
    psum  = 21'(pitch);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      efc_pkg::S_IDLE:
        if (in_valid) begin
          if (restart)            state_next = efc_pkg::S_START;
          else if (manual_enable) state_next = efc_pkg::S_DX_ISS;
          else                    state_next = efc_pkg::S_FOLD;
        end
      efc_pkg::S_START:   state_next = efc_pkg::S_FOLD;
      efc_pkg::S_DX_ISS:  state_next = efc_pkg::S_DX_USE;
      efc_pkg::S_DX_USE:  state_next = efc_pkg::S_DY_USE;
      efc_pkg::S_DY_USE:  state_next = efc_pkg::S_VEL_USE;
      efc_pkg::S_VEL_USE: state_next = efc_pkg::S_WRAP;
      efc_pkg::S_WRAP:
        if (ysum >= 0 && ysum < $signed({4'd0, efc_pkg::FULL_TURN}))
          state_next = efc_pkg::S_FS_ISS;
      efc_pkg::S_FS_ISS:  state_next = efc_pkg::S_FS_USE;
      efc_pkg::S_FS_USE:  state_next = efc_pkg::S_RS_ISS;
      efc_pkg::S_RS_ISS:  state_next = efc_pkg::S_RS_USE;
      efc_pkg::S_RS_USE:  state_next = efc_pkg::S_APPLY;
      efc_pkg::S_APPLY:
        if (kcnt == 2'd3) state_next = (idx == 2'd2) ? efc_pkg::S_FOLD : efc_pkg::S_FS_ISS;
      efc_pkg::S_FOLD:    state_next = efc_pkg::S_X_USE;
      efc_pkg::S_X_USE:   state_next = efc_pkg::S_X2_ISS;
      efc_pkg::S_X2_ISS:  state_next = efc_pkg::S_X2_USE;
      efc_pkg::S_X2_USE:  state_next = efc_pkg::S_PM_ISS;
      efc_pkg::S_PM_ISS:  state_next = efc_pkg::S_PM_USE;
      efc_pkg::S_PM_USE:  state_next = efc_pkg::S_RC_USE;
      efc_pkg::S_RC_USE:  state_next = efc_pkg::S_QD_USE;
      efc_pkg::S_QD_USE:
        if (j == efc_pkg::SIN_LAST)      state_next = efc_pkg::S_SIN_ISS;
        else if (j == efc_pkg::COS_LAST) state_next = efc_pkg::S_QUAD;
        else                             state_next = efc_pkg::S_PM_ISS;
      efc_pkg::S_SIN_ISS: state_next = efc_pkg::S_SIN_USE;
      efc_pkg::S_SIN_USE: state_next = efc_pkg::S_PM_ISS;
      efc_pkg::S_QUAD:    state_next = sel ? efc_pkg::S_PR_ISS : efc_pkg::S_FOLD;
      efc_pkg::S_PR_ISS:  state_next = efc_pkg::S_PR_USE;
      efc_pkg::S_PR_USE:  state_next = (pk == 2'd3) ? efc_pkg::S_DONE : efc_pkg::S_PR_ISS;
      efc_pkg::S_DONE:    if (out_free) state_next = efc_pkg::S_IDLE;
      default:            state_next = efc_pkg::S_IDLE;
    endcase
  end

  // Multiplier operand selection
  always_comb begin
    ma = 32'd0;
    mb = 32'd0;
    case (state)
      efc_pkg::S_DX_ISS: begin ma = {20'd0, dx_mag}; mb = {16'd0, look_gain}; end
      efc_pkg::S_DX_USE: begin ma = {20'd0, dy_mag}; mb = {16'd0, look_gain}; end
      efc_pkg::S_DY_USE: begin ma = {16'd0, move_speed}; mb = {16'd0, l_dt}; end
      efc_pkg::S_FS_ISS: begin ma = {16'd0, fv_mag}; mb = vel; end
      efc_pkg::S_RS_ISS: begin ma = {16'd0, rv_mag}; mb = vel; end
      efc_pkg::S_FOLD:   begin ma = {15'd0, rr}; mb = efc_pkg::RAD_Q30; end
      efc_pkg::S_X2_ISS: begin ma = {2'd0, x}; mb = {2'd0, x}; end
      efc_pkg::S_PM_ISS: begin ma = {1'b0, x2}; mb = {1'b0, t}; end
      efc_pkg::S_PM_USE: begin ma = {1'b0, rnd30}; mb = efc_pkg::poly_recip(j); end
      efc_pkg::S_RC_USE: begin ma = {2'd0, mp[61:32]}; mb = {24'd0, efc_pkg::poly_div(j)}; end
      efc_pkg::S_SIN_ISS: begin ma = {2'd0, x}; mb = {1'b0, t}; end
      efc_pkg::S_PR_ISS: begin
        ma = pa[31] ? (32'd0 - pa) : pa;
        mb = pb[31] ? (32'd0 - pb) : pb;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= efc_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == efc_pkg::S_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall)                      out_valid <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    logic [19:0]        dm;
    logic signed [20:0] ds;
    logic signed [20:0] ps;
    logic signed [25:0] st;
    if (rst) begin
      yaw   <= 17'd0;
      pitch <= 16'sd0;
      for (int i = 0; i < 3; i++) pos[i] <= 32'sd0;
      front[0] <= efc_pkg::VEC_MAX; front[1] <= 16'sd0; front[2] <= 16'sd0;
      right[0] <= 16'sd0; right[1] <= 16'sd0; right[2] <= efc_pkg::VEC_MAX;
    end else begin
      dm = d_mag;
      ds = d_sig;
      ps = psum;
      st = 26'sd0;
      case (state)
        efc_pkg::S_IDLE:
          if (in_valid) begin
            l_dx <= mouse_dx;
            l_dy <= mouse_dy;
            l_keys <= {key_right, key_left, key_back, key_forward};
            l_dt <= dt;
            sel <= 1'b0;
          end
        efc_pkg::S_START: begin
          yaw <= (start_yaw >= efc_pkg::FULL_TURN) ? (start_yaw - efc_pkg::FULL_TURN)
                                                   : start_yaw;
          ps = 21'($signed(start_pitch));
          if (ps > efc_pkg::PITCH_LIM)       pitch <= 16'(efc_pkg::PITCH_LIM);
          else if (ps < -efc_pkg::PITCH_LIM) pitch <= 16'(-efc_pkg::PITCH_LIM);
          else                               pitch <= ps[15:0];
          pos[0] <= start_x;
          pos[1] <= start_y;
          pos[2] <= start_z;
        end
        efc_pkg::S_DX_USE: begin
          ds = l_dx[11] ? -$signed({1'b0, dm}) : $signed({1'b0, dm});
          ysum <= $signed({4'd0, yaw}) + ds;
        end
        efc_pkg::S_DY_USE: begin
          ds = l_dy[11] ? -$signed({1'b0, dm}) : $signed({1'b0, dm});
          ps = 21'(pitch) + ds;
          if (ps > efc_pkg::PITCH_LIM)       pitch <= 16'(efc_pkg::PITCH_LIM);
          else if (ps < -efc_pkg::PITCH_LIM) pitch <= 16'(-efc_pkg::PITCH_LIM);
          else                               pitch <= ps[15:0];
        end
        efc_pkg::S_VEL_USE: begin
          vel <= mp[31:0];
          idx <= 2'd0;
        end
        efc_pkg::S_WRAP: begin
          if (ysum < 0)
            ysum <= ysum + $signed({4'd0, efc_pkg::FULL_TURN});
          else if (ysum >= $signed({4'd0, efc_pkg::FULL_TURN}))
            ysum <= ysum - $signed({4'd0, efc_pkg::FULL_TURN});
          else
            yaw <= ysum[16:0];
        end
        efc_pkg::S_FS_USE: begin
          st = $signed({1'b0, step_mag});
          fs <= front[idx][15] ? -st : st;
        end
        efc_pkg::S_RS_USE: begin
          st = $signed({1'b0, step_mag});
          rs <= right[idx][15] ? -st : st;
          kcnt <= 2'd0;
        end
        efc_pkg::S_APPLY: begin
          if (key_on) pos[idx] <= pos_sat;
          kcnt <= kcnt + 2'd1;
          if (kcnt == 2'd3) idx <= idx + 2'd1;
        end
        efc_pkg::S_FOLD: begin
          quad <= q_u;
          swap <= (r_u > efc_pkg::EIGHTH_TURN);
        end
        efc_pkg::S_X_USE:  x <= 30'((mp[38:0] + 39'd128) >> 8);
        efc_pkg::S_X2_USE: begin
          x2 <= rnd30;
          t  <= efc_pkg::TRIG_ONE;
          j  <= 4'd0;
        end
        efc_pkg::S_PM_USE: pm <= rnd30;
        efc_pkg::S_RC_USE: q0 <= mp[61:32];
        efc_pkg::S_QD_USE: begin
          t <= t_new;
          if (j == efc_pkg::COS_LAST) c0 <= t_new;
          else if (j != efc_pkg::SIN_LAST) j <= j + 4'd1;
        end
        efc_pkg::S_SIN_USE: begin
          s0 <= rnd30;
          t  <= efc_pkg::TRIG_ONE;
          j  <= 4'd5;
        end
        efc_pkg::S_QUAD: begin
          // Store the finished sine and cosine of yaw, then of pitch
          if (sel) begin
            sp <= s_q;
            cp <= c_q;
          end else begin
            sy <= s_q;
            cy <= c_q;
          end
          sel <= 1'b1;
          pk  <= 2'd0;
        end
        efc_pkg::S_PR_USE: begin
          case (pk)
            2'd0:    front[0] <= efc_pkg::quant(prod_s);
            2'd1:    front[2] <= efc_pkg::quant(prod_s);
            2'd2:    upx <= efc_pkg::quant(-prod_s);
            default: upz <= efc_pkg::quant(-prod_s);
          endcase
          pk <= pk + 2'd1;
        end
        efc_pkg::S_DONE:
          if (out_free) begin
            front[1] <= efc_pkg::quant(sp);
            right[0] <= efc_pkg::quant(-sy);
            right[1] <= 16'sd0;
            right[2] <= efc_pkg::quant(cy);
          end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == efc_pkg::S_DONE && out_free) begin
      pos_x   <= pos[0];
      pos_y   <= pos[1];
      pos_z   <= pos[2];
      front_x <= front[0];
      front_y <= efc_pkg::quant(sp);
      front_z <= front[2];
      right_x <= efc_pkg::quant(-sy);
      right_y <= 16'sd0;
      right_z <= efc_pkg::quant(cy);
      up_x    <= upx;
      up_y    <= efc_pkg::quant(cp);
      up_z    <= upz;
    end
  end

endmodule
`default_nettype wire
